FILE: sv/rme_pkg.sv
// shared types and constants for the rsa modular exponentiation block
`timescale 1ns / 1ps

package rme_pkg;

  localparam int DEF_OPERAND_WIDTH = 32;
  localparam int DATA_WIDTH        = 32;
  localparam int PIXEL_WIDTH       = 16;
  localparam int ADDR_WIDTH        = 4;

  localparam logic [DATA_WIDTH-1:0] RESET_MODULUS          = 32'd2654651759;
  localparam logic [DATA_WIDTH-1:0] RESET_PUBLIC_EXPONENT  = 32'd7;
  localparam logic [DATA_WIDTH-1:0] RESET_PRIVATE_EXPONENT = 32'd758442487;

  typedef enum logic [1:0] {
    REG_MODULUS          = 2'd0,
    REG_PUBLIC_EXPONENT  = 2'd1,
    REG_PRIVATE_EXPONENT = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_RED_STEP,
    DP_BASE,
    DP_SQ_INIT,
    DP_MU_INIT,
    DP_MUL_STEP,
    DP_MUL_DONE,
    DP_NEXT_BIT,
    DP_EMIT
  } dp_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RED,
    ST_BASE,
    ST_SQ_INIT,
    ST_SQ,
    ST_SQ_DONE,
    ST_MU_INIT,
    ST_MU,
    ST_MU_DONE,
    ST_NEXT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic m_small;
    logic e_msb;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: sv/rme_ifs.sv
// valid/ready channel interfaces for items and results
`timescale 1ns / 1ps

interface rme_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [rme_pkg::DATA_WIDTH-1:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

interface rme_out_if;
  logic                         valid;
  logic                         ready;
  logic [rme_pkg::DATA_WIDTH-1:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

FILE: sv/rsa_modular_exponentiation.sv
// top level: configuration registers, controller and datapath
`timescale 1ns / 1ps

// Computes value^e mod n for one item at a time, with e the public exponent on
// encrypt (only the low 16 bits of value used) and the private exponent on
// decrypt (only the low 16 bits of the result kept); a modulus below 2 gives 0.
// All work runs on one shared modular multiply unit that retires one multiplier
// bit per cycle; a modulus below 2 goes straight to the output register without
// the multiply passes. A result that still waits in the output register holds off
// the next one for as long as it waits. The next item can be taken in the cycle
// after the result is parked in the output register. Configuration is by APB
// writes at byte offsets 0, 4 and 8 (modulus, public and private exponent),
// made while no item is in flight.
module rsa_modular_exponentiation #(
  parameter int OPERAND_WIDTH = rme_pkg::DEF_OPERAND_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rme_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [rme_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [rme_pkg::DATA_WIDTH-1:0] prdata,
  output logic                           pready,
  rme_in_if.sink                         in_i,
  rme_out_if.source                      out_o
);

  logic [rme_pkg::DATA_WIDTH-1:0] modulus_q, public_exponent_q, private_exponent_q;
  rme_pkg::cfg_reg_e              reg_idx;
  logic                           cfg_wr;
  rme_pkg::dp_cmd_e               cmd;
  rme_pkg::dp_status_t            status;

  assign reg_idx = rme_pkg::cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_idx)
      rme_pkg::REG_MODULUS:          prdata = modulus_q;
      rme_pkg::REG_PUBLIC_EXPONENT:  prdata = public_exponent_q;
      rme_pkg::REG_PRIVATE_EXPONENT: prdata = private_exponent_q;
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q          <= rme_pkg::RESET_MODULUS;
      public_exponent_q  <= rme_pkg::RESET_PUBLIC_EXPONENT;
      private_exponent_q <= rme_pkg::RESET_PRIVATE_EXPONENT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rme_pkg::REG_MODULUS:          modulus_q          <= pwdata;
        rme_pkg::REG_PUBLIC_EXPONENT:  public_exponent_q  <= pwdata;
        rme_pkg::REG_PRIVATE_EXPONENT: private_exponent_q <= pwdata;
        default: begin
        end
      endcase
    end
  end

  rme_ctrl #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rme_dp #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .operation_i        (in_i.operation),
    .value_i            (in_i.value),
    .modulus_i          (modulus_q),
    .public_exponent_i  (public_exponent_q),
    .private_exponent_i (private_exponent_q),
    .status_o           (status),
    .out_o              (out_o)
  );

endmodule

FILE: sv/rme_dp.sv
// datapath: base reduction, shift-and-add modular multiply, result register
`timescale 1ns / 1ps

module rme_dp #(
  parameter int OPERAND_WIDTH = rme_pkg::DEF_OPERAND_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rme_pkg::dp_cmd_e               cmd_i,
  input  logic                           operation_i,
  input  logic [rme_pkg::DATA_WIDTH-1:0] value_i,
  input  logic [rme_pkg::DATA_WIDTH-1:0] modulus_i,
  input  logic [rme_pkg::DATA_WIDTH-1:0] public_exponent_i,
  input  logic [rme_pkg::DATA_WIDTH-1:0] private_exponent_i,
  output rme_pkg::dp_status_t            status_o,
  rme_out_if.source                      out_o
);

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = rme_pkg::DATA_WIDTH;
  localparam int PW = rme_pkg::PIXEL_WIDTH;

  logic [W-1:0]  m_q, e_q, base_q, res_q, acc_q, sh_q;
  logic [W-1:0]  m_d, e_d, base_d, res_d, acc_d, sh_d;
  logic          dec_q, dec_d;
  logic          out_valid_q, out_valid_d;
  logic [DW-1:0] out_result_q, out_result_d;

  logic [W:0]    dbl, dbl_sub, sum, sum_sub;
  logic [W-1:0]  dbl_r, addend, step_r;
  logic [DW-1:0] v_load, res_full;

  // one step: acc = (2*acc + addend) mod m, both parts below m
  always_comb begin
    dbl     = {acc_q, 1'b0};
    dbl_sub = dbl - {1'b0, m_q};
    dbl_r   = (dbl >= {1'b0, m_q}) ? dbl_sub[W-1:0] : dbl[W-1:0];
    if (!sh_q[W-1]) begin
      addend = '0;
    end else if (cmd_i == rme_pkg::DP_RED_STEP) begin
      addend = W'(1);
    end else begin
      addend = res_q;
    end
    sum     = {1'b0, dbl_r} + {1'b0, addend};
    sum_sub = sum - {1'b0, m_q};
    step_r  = (sum >= {1'b0, m_q}) ? sum_sub[W-1:0] : sum[W-1:0];
  end

  always_comb begin
    v_load = (operation_i == rme_pkg::OP_DECRYPT) ? value_i
                                                  : {{(DW-PW){1'b0}}, value_i[PW-1:0]};
    res_full = DW'(res_q);
    if (status_o.m_small) begin
      out_result_d = '0;
    end else if (dec_q) begin
      out_result_d = {{(DW-PW){1'b0}}, res_full[PW-1:0]};
    end else begin
      out_result_d = res_full;
    end
  end

  always_comb begin
    m_d         = m_q;
    e_d         = e_q;
    base_d      = base_q;
    res_d       = res_q;
    acc_d       = acc_q;
    sh_d        = sh_q;
    dec_d       = dec_q;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (cmd_i)
      rme_pkg::DP_LOAD: begin
        m_d   = W'(modulus_i);
        e_d   = (operation_i == rme_pkg::OP_DECRYPT) ? W'(private_exponent_i)
                                                     : W'(public_exponent_i);
        dec_d = operation_i;
        sh_d  = W'(v_load);
        acc_d = '0;
        res_d = W'(1);
      end
      rme_pkg::DP_RED_STEP, rme_pkg::DP_MUL_STEP: begin
        acc_d = step_r;
        sh_d  = {sh_q[W-2:0], 1'b0};
      end
      rme_pkg::DP_BASE: begin
        base_d = acc_q;
      end
      rme_pkg::DP_SQ_INIT: begin
        acc_d = '0;
        sh_d  = res_q;
      end
      rme_pkg::DP_MU_INIT: begin
        acc_d = '0;
        sh_d  = base_q;
      end
      rme_pkg::DP_MUL_DONE: begin
        res_d = acc_q;
      end
      rme_pkg::DP_NEXT_BIT: begin
        e_d = {e_q[W-2:0], 1'b0};
      end
      rme_pkg::DP_EMIT: begin
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    e_q    <= e_d;
    base_q <= base_d;
    res_q  <= res_d;
    acc_q  <= acc_d;
    sh_q   <= sh_d;
    dec_q  <= dec_d;
    if (cmd_i == rme_pkg::DP_EMIT) begin
      out_result_q <= out_result_d;
    end
  end

  assign status_o.m_small  = (m_q < W'(2));
  assign status_o.e_msb    = e_q[W-1];
  assign status_o.out_busy = out_valid_q && !out_o.ready;

  assign out_o.valid  = out_valid_q;
  assign out_o.result = out_result_q;

  // accumulator and multiplicand stay reduced while a product is formed
  a_mul_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == rme_pkg::DP_MUL_STEP) |-> (acc_q < m_q) && (res_q < m_q))
    else $error("multiply operand not reduced");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == rme_pkg::DP_EMIT) |=> out_valid_q)
    else $error("emitted result not presented");

endmodule

FILE: sv/rme_ctrl.sv
// controller: sequences reduction, square and multiply passes per exponent bit
`timescale 1ns / 1ps

module rme_ctrl #(
  parameter int OPERAND_WIDTH = rme_pkg::DEF_OPERAND_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rme_pkg::dp_status_t status_i,
  output rme_pkg::dp_cmd_e    cmd_o
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);

  rme_pkg::state_e state_q, state_d;
  logic [CW-1:0]   step_cnt_q, bit_cnt_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rme_pkg::ST_IDLE:    if (in_valid_i) state_d = rme_pkg::ST_CHECK;
      rme_pkg::ST_CHECK:   state_d = status_i.m_small ? rme_pkg::ST_FINISH : rme_pkg::ST_RED;
      rme_pkg::ST_RED:     if (step_cnt_q == '0) state_d = rme_pkg::ST_BASE;
      rme_pkg::ST_BASE:    state_d = rme_pkg::ST_SQ_INIT;
      rme_pkg::ST_SQ_INIT: state_d = rme_pkg::ST_SQ;
      rme_pkg::ST_SQ:      if (step_cnt_q == '0) state_d = rme_pkg::ST_SQ_DONE;
      rme_pkg::ST_SQ_DONE: state_d = status_i.e_msb ? rme_pkg::ST_MU_INIT : rme_pkg::ST_NEXT;
      rme_pkg::ST_MU_INIT: state_d = rme_pkg::ST_MU;
      rme_pkg::ST_MU:      if (step_cnt_q == '0) state_d = rme_pkg::ST_MU_DONE;
      rme_pkg::ST_MU_DONE: state_d = rme_pkg::ST_NEXT;
      rme_pkg::ST_NEXT:    state_d = (bit_cnt_q == '0) ? rme_pkg::ST_FINISH
                                                       : rme_pkg::ST_SQ_INIT;
      rme_pkg::ST_FINISH:  if (!status_i.out_busy) state_d = rme_pkg::ST_IDLE;
      default:             state_d = rme_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = rme_pkg::DP_IDLE;
    in_ready_o = 1'b0;
    unique case (state_q)
      rme_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o = rme_pkg::DP_LOAD;
      end
      rme_pkg::ST_RED:     cmd_o = rme_pkg::DP_RED_STEP;
      rme_pkg::ST_BASE:    cmd_o = rme_pkg::DP_BASE;
      rme_pkg::ST_SQ_INIT: cmd_o = rme_pkg::DP_SQ_INIT;
      rme_pkg::ST_MU_INIT: cmd_o = rme_pkg::DP_MU_INIT;
      rme_pkg::ST_SQ,
      rme_pkg::ST_MU:      cmd_o = rme_pkg::DP_MUL_STEP;
      rme_pkg::ST_SQ_DONE,
      rme_pkg::ST_MU_DONE: cmd_o = rme_pkg::DP_MUL_DONE;
      rme_pkg::ST_NEXT:    cmd_o = rme_pkg::DP_NEXT_BIT;
      rme_pkg::ST_FINISH:  if (!status_i.out_busy) cmd_o = rme_pkg::DP_EMIT;
      default:             cmd_o = rme_pkg::DP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rme_pkg::ST_IDLE;
      step_cnt_q <= '0;
      bit_cnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == rme_pkg::ST_CHECK || state_q == rme_pkg::ST_SQ_INIT ||
          state_q == rme_pkg::ST_MU_INIT) begin
        step_cnt_q <= CW'(W - 1);
      end else if (state_q == rme_pkg::ST_RED || state_q == rme_pkg::ST_SQ ||
                   state_q == rme_pkg::ST_MU) begin
        step_cnt_q <= step_cnt_q - 1'b1;
      end
      if (state_q == rme_pkg::ST_BASE) begin
        bit_cnt_q <= CW'(W - 1);
      end else if (state_q == rme_pkg::ST_NEXT) begin
        bit_cnt_q <= bit_cnt_q - 1'b1;
      end
    end
  end

  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == rme_pkg::ST_CHECK))
    else $error("accepted item not sequenced");

  a_red_to_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rme_pkg::ST_RED && step_cnt_q == '0) |=> (state_q == rme_pkg::ST_BASE))
    else $error("reduction pass length wrong");

  a_finish_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rme_pkg::ST_FINISH && status_i.out_busy) |=> (state_q == rme_pkg::ST_FINISH))
    else $error("result dropped while output busy");

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the rsa modular exponentiation block
`timescale 1ns / 1ps

module tb_top;
  import rme_pkg::*;

  localparam int          CLK_PERIOD      = 12;
  localparam longint      TIMEOUT_CYCLES  = 10_000_000;
  localparam int          NUM_PHASES      = 9;
  localparam int          ITEMS_PER_PHASE = 78;
  localparam int          SETTLE_CYCLES   = 2500;
  localparam int          LONG_HOLD       = 6000;
  localparam logic [1:0]  REG_UNMAPPED    = 2'd3;

  typedef enum logic { ROW_WRITE, ROW_ITEM } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    op_e         op;
    logic [31:0] word;
    logic        typed;
    logic [31:0] want;
  } stim_row_t;

  localparam int NUM_DIRECTED = 32;

  // rows with typed == 0 are checked against the predictor
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{ROW_ITEM,  REG_MODULUS,          OP_ENCRYPT, 32'h0000_0000, 1'b1, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_ENCRYPT, 32'h0000_0001, 1'b1, 32'd1},
    '{ROW_ITEM,  REG_MODULUS,          OP_ENCRYPT, 32'hFFFF_0002, 1'b0, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_ENCRYPT, 32'h0000_FFFF, 1'b0, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_DECRYPT, 32'h0000_0000, 1'b1, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_DECRYPT, 32'h0000_0001, 1'b1, 32'd1},
    '{ROW_ITEM,  REG_MODULUS,          OP_DECRYPT, RESET_MODULUS, 1'b1, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_DECRYPT, 32'hFFFF_FFFF, 1'b0, 32'd0},
    '{ROW_WRITE, REG_PUBLIC_EXPONENT,  OP_ENCRYPT, 32'h0000_0000, 1'b0, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_ENCRYPT, 32'h0000_1234, 1'b1, 32'd1},
    '{ROW_ITEM,  REG_MODULUS,          OP_ENCRYPT, 32'h0000_0000, 1'b1, 32'd1},
    '{ROW_WRITE, REG_PRIVATE_EXPONENT, OP_ENCRYPT, 32'h0000_0000, 1'b0, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_DECRYPT, 32'hFFFF_FFFF, 1'b1, 32'd1},
    '{ROW_WRITE, REG_MODULUS,          OP_ENCRYPT, 32'h0000_0000, 1'b0, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_ENCRYPT, 32'h0000_0005, 1'b1, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_DECRYPT, 32'hFFFF_FFFF, 1'b1, 32'd0},
    '{ROW_WRITE, REG_MODULUS,          OP_ENCRYPT, 32'h0000_0001, 1'b0, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_ENCRYPT, 32'h0000_FFFF, 1'b1, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_DECRYPT, 32'h0000_0007, 1'b1, 32'd0},
    '{ROW_WRITE, REG_MODULUS,          OP_ENCRYPT, 32'h0000_0002, 1'b0, 32'd0},
    '{ROW_WRITE, REG_PUBLIC_EXPONENT,  OP_ENCRYPT, 32'hFFFF_FFFF, 1'b0, 32'd0},
    '{ROW_WRITE, REG_PRIVATE_EXPONENT, OP_ENCRYPT, 32'hFFFF_FFFF, 1'b0, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_ENCRYPT, 32'h0000_0003, 1'b1, 32'd1},
    '{ROW_ITEM,  REG_MODULUS,          OP_DECRYPT, 32'h0000_0004, 1'b1, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_ENCRYPT, 32'hFFFF_0000, 1'b1, 32'd0},
    '{ROW_WRITE, REG_UNMAPPED,         OP_ENCRYPT, 32'h0000_0000, 1'b0, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_ENCRYPT, 32'h0000_0007, 1'b1, 32'd1},
    '{ROW_WRITE, REG_MODULUS,          OP_ENCRYPT, 32'hFFFF_FFFF, 1'b0, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_ENCRYPT, 32'h0000_FFFF, 1'b0, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_DECRYPT, 32'hFFFF_FFFE, 1'b0, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_DECRYPT, 32'hFFFF_FFFF, 1'b1, 32'd0},
    '{ROW_ITEM,  REG_MODULUS,          OP_ENCRYPT, 32'h0000_0000, 1'b1, 32'd0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [DATA_WIDTH-1:0] pwdata;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  rme_in_if  in_if ();
  rme_out_if out_if ();

  rsa_modular_exponentiation u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  // key registers as the block should hold them
  logic [31:0] key_modulus  = RESET_MODULUS;
  logic [31:0] key_public   = RESET_PUBLIC_EXPONENT;
  logic [31:0] key_private  = RESET_PRIVATE_EXPONENT;

  logic [31:0] expected_results [$];
  int          mismatch_count  = 0;
  int          send_idle_pct   = 0;
  int          recv_idle_pct   = 0;
  int          hold_off_cycles = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAILURE");
    $finish;
  end

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < 50) begin
      $display("[%0t] mismatch: %s got %h want %h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // square-and-multiply from the top exponent bit, base reduced first
  function automatic logic [31:0] modexp_result(op_e op, logic [31:0] v);
    logic [63:0] m;
    logic [63:0] acc;
    logic [63:0] b;
    logic [31:0] e;
    if (key_modulus < 32'd2) return 32'd0;
    m   = {32'd0, key_modulus};
    e   = (op == OP_DECRYPT) ? key_private : key_public;
    b   = (op == OP_DECRYPT) ? ({32'd0, v} % m) : ({48'd0, v[15:0]} % m);
    acc = 64'd1;
    for (int i = 31; i >= 0; i--) begin
      acc = (acc * acc) % m;
      if (e[i]) acc = (acc * b) % m;
    end
    return (op == OP_DECRYPT) ? {16'd0, acc[15:0]} : acc[31:0];
  endfunction

  // receiver: random stalls, long hold-off on request, result checking
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result with none pending", out_if.result, 32'd0);
        end else begin
          logic [31:0] want;
          want = expected_results.pop_front();
          if (out_if.result !== want) flag_mismatch("result", out_if.result, want);
        end
      end
      if (hold_off_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(op_e op, logic [31:0] v, logic [31:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.value     <= v;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_results.push_back(want);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODULUS:          key_modulus = data;
      REG_PUBLIC_EXPONENT:  key_public  = data;
      REG_PRIVATE_EXPONENT: key_private = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic check_registers();
    cfg_reg_e    r;
    logic [31:0] want;
    r = r.first();
    repeat (r.num()) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {r, 2'b00};
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      case (r)
        REG_MODULUS:         want = key_modulus;
        REG_PUBLIC_EXPONENT: want = key_public;
        default:             want = key_private;
      endcase
      if (prdata !== want) flag_mismatch(r.name(), prdata, want);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
      r = r.next();
    end
  endtask

  task automatic load_keys(logic [31:0] m, logic [31:0] e, logic [31:0] d);
    drain_results();
    cfg_write(REG_MODULUS, m);
    cfg_write(REG_PUBLIC_EXPONENT, e);
    cfg_write(REG_PRIVATE_EXPONENT, d);
    check_registers();
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return $urandom_range(3);
      1:       return 32'hFFFF_FFFF - $urandom_range(3);
      2:       return key_modulus;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    stim_row_t   row;
    op_e         op;
    logic [31:0] v;
    logic [31:0] cipher;
    logic [31:0] upper;
    bit          key_pair_phase;

    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid     = 1'b0;
    in_if.operation = OP_ENCRYPT;
    in_if.value     = '0;
    cipher          = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_registers();
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_WRITE) begin
        drain_results();
        cfg_write(row.reg_idx, row.word);
      end else begin
        send_item(row.op, row.word, row.typed ? row.want : modexp_result(row.op, row.word));
      end
    end
    drain_results();
    check_registers();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase / 3)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 52;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        0, 7: load_keys(RESET_MODULUS, RESET_PUBLIC_EXPONENT, RESET_PRIVATE_EXPONENT);
        1: load_keys($urandom | 32'h8000_0000, $urandom, $urandom);
        2: load_keys($urandom_range(300, 2), $urandom, $urandom);
        3: load_keys(32'hFFFF_FFFF, $urandom, 32'hFFFF_FFFF);
        4: load_keys($urandom, 32'd0, $urandom);
        5: load_keys($urandom_range(1, 0), $urandom, $urandom);
        6: load_keys($urandom, 32'hFFFF_FFFF, 32'd0);
        default: load_keys($urandom, $urandom, $urandom);
      endcase
      key_pair_phase = (phase == 0) || (phase == 7);

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // block parks one result and stalls its input behind it
        if (phase == 1 && k == 10) hold_off_cycles = LONG_HOLD;
        if (phase == 4 && k == 40) drain_results();
        if (key_pair_phase && k % 2 == 0) begin
          upper = ($urandom_range(3) == 0) ? $urandom : 32'd0;
          v     = {upper[31:16], 16'($urandom)};
          op    = OP_ENCRYPT;
          cipher = modexp_result(op, v);
        end else if (key_pair_phase && $urandom_range(4) != 0) begin
          // decrypt the ciphertext just produced, should give the pixel back
          op = OP_DECRYPT;
          v  = cipher;
        end else begin
          op = op_e'($urandom_range(1));
          v  = pick_value();
        end
        send_item(op, v, modexp_result(op, v));
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
